FILE: hw/rtl/fbfr_pkg.sv
package fbfr_pkg;

	localparam int BUF_BYTES = 4096;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	localparam int LEN_W     = 13;
	localparam int STEP_W    = 4;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] AT_U8  = 2'd0;
	localparam logic [1:0] AT_U16 = 2'd1;
	localparam logic [1:0] AT_U32 = 2'd2;
	localparam logic [1:0] AT_OFF = 2'd3;

	localparam logic [1:0] ST_PRESENT = 2'd0;
	localparam logic [1:0] ST_ABSENT  = 2'd1;
	localparam logic [1:0] ST_BOUNDS  = 2'd2;
	localparam logic [1:0] ST_NEGVT   = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
		logic [11:0] table_position;
		logic [15:0] field_index;
		logic [1:0]  access_type;
		logic [31:0] default_value;
	} cmd_t;

	typedef struct packed {
		logic [32:0] value;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] pos;
		logic [2:0]        nbytes;
	} rd_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] word;
	} rd_rsp_t;

	typedef enum logic [3:0] {
		U_NOP,
		U_TBL,
		U_VTCALC,
		U_VTCHK,
		U_SLOT,
		U_SCHK,
		U_FPOS,
		U_FCHK,
		U_FIN
	} uop_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_START,
		J_RD,
		J_CHECK,
		J_EMIT,
		J_GOTO
	} ujmp_t;

	typedef struct packed {
		uop_t              op;
		ujmp_t             jmp;
		logic [STEP_W-1:0] target;
	} ucw_t;

	localparam logic [STEP_W-1:0] P_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] P_EMIT = 4'd13;

	// lookup microprogram
	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t cw;
		case (step)
			4'd0: cw = '{op: U_NOP, jmp: J_START, target: P_IDLE};
			4'd1: cw = '{op: U_TBL, jmp: J_CHECK, target: P_EMIT};
			4'd2: cw = '{op: U_NOP, jmp: J_RD, target: P_IDLE};
			4'd3: cw = '{op: U_VTCALC, jmp: J_NEXT, target: P_IDLE};
			4'd4: cw = '{op: U_VTCHK, jmp: J_CHECK, target: P_EMIT};
			4'd5: cw = '{op: U_NOP, jmp: J_RD, target: P_IDLE};
			4'd6: cw = '{op: U_SLOT, jmp: J_CHECK, target: P_EMIT};
			4'd7: cw = '{op: U_SCHK, jmp: J_CHECK, target: P_EMIT};
			4'd8: cw = '{op: U_NOP, jmp: J_RD, target: P_IDLE};
			4'd9: cw = '{op: U_FPOS, jmp: J_CHECK, target: P_EMIT};
			4'd10: cw = '{op: U_FCHK, jmp: J_CHECK, target: P_EMIT};
			4'd11: cw = '{op: U_NOP, jmp: J_RD, target: P_IDLE};
			4'd12: cw = '{op: U_FIN, jmp: J_NEXT, target: P_IDLE};
			4'd13: cw = '{op: U_NOP, jmp: J_EMIT, target: P_IDLE};
			default: cw = '{op: U_NOP, jmp: J_GOTO, target: P_IDLE};
		endcase
		return cw;
	endfunction

endpackage

FILE: hw/rtl/fbfr_rdu.sv
module fbfr_rdu (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fbfr_pkg::ADDR_W-1:0]      wr_addr,
	input  logic [7:0]                       wr_data,
	input  fbfr_pkg::rd_req_t                req,
	output fbfr_pkg::rd_rsp_t                rsp
);
	import fbfr_pkg::*;

	logic [7:0]        mem [BUF_BYTES];
	logic [7:0]        rdata_q;
	logic              busy_q;
	logic [ADDR_W-1:0] pos_q;
	logic [2:0]        n_q;
	logic [2:0]        iss_q;
	logic [2:0]        rcv_q;
	logic              pend_q;
	logic              done_q;
	logic [31:0]       word_q;
	logic              issue;

	assign issue = busy_q && (iss_q != n_q);

	// byte store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rdata_q <= mem[pos_q + ADDR_W'(iss_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iss_q  <= '0;
			rcv_q  <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			n_q    <= req.nbytes;
			iss_q  <= '0;
			rcv_q  <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pend_q <= issue;
			done_q <= pend_q && (rcv_q + 3'd1 == n_q);
			if (issue) begin
				iss_q <= iss_q + 3'd1;
			end
			if (pend_q) begin
				rcv_q <= rcv_q + 3'd1;
				if (rcv_q + 3'd1 == n_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// little-endian assembly
	always_ff @(posedge clk) begin
		if (req.start) begin
			pos_q  <= req.pos;
			word_q <= '0;
		end else if (pend_q) begin
			word_q[{rcv_q[1:0], 3'b000} +: 8] <= rdata_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.word = word_q;

endmodule

FILE: hw/rtl/flatbuffer_field_reader.sv
// a load request is taken and gives no result
// a query runs the lookup microprogram over a byte-wide store; a check can end it early,
// and its length is set by the dependent byte reads
// one request in flight; the next is accepted once the result is in the output register
// arst_n clears the step counter, buffer_length and the output valid; store contents
// stay undefined until written
module flatbuffer_field_reader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  fbfr_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_stall,
	output fbfr_pkg::res_t                res,
	input  logic                          len_we,
	input  logic [fbfr_pkg::LEN_W-1:0]    len_wdata
);
	import fbfr_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_nxt;
	ucw_t              cw;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  vlen;

	logic [11:0]       tbl_q;
	logic [15:0]       fid_q;
	logic [1:0]        acc_q;
	logic [31:0]       def_q;
	logic [33:0]       vt_q;
	logic [18:0]       sa_q;
	logic [16:0]       fpos_q;
	logic [32:0]       rval_q;
	logic [1:0]        rst_q;
	res_t              res_q;
	logic              res_valid_q;

	logic              cmd_go;
	logic              query_go;
	logic              load_go;
	logic              out_free;
	logic              emit_go;
	logic              fail;
	logic [1:0]        fail_st;
	logic [32:0]       fail_val;
	logic [2:0]        nb;
	logic [17:0]       slot;
	logic [17:0]       slot_end;
	rd_req_t           rd_req;
	rd_rsp_t           rd_rsp;

	assign cw        = ucode(pc_q);
	assign cmd_stall = (pc_q != P_IDLE);
	assign cmd_go    = cmd_valid && !cmd_stall;
	assign query_go  = cmd_go && (cmd.kind == KIND_QUERY);
	assign load_go   = cmd_go && (cmd.kind == KIND_LOAD);
	assign out_free  = !res_valid_q || !res_stall;
	assign emit_go   = (cw.jmp == J_EMIT) && out_free;
	assign vlen      = (len_q > LEN_W'(BUF_BYTES)) ? LEN_W'(BUF_BYTES) : len_q;
	assign slot      = {1'b0, fid_q, 1'b0} + 18'd4;
	assign slot_end  = slot + 18'd2;

	always_comb begin
		case (acc_q)
			AT_U8:   nb = 3'd1;
			AT_U16:  nb = 3'd2;
			default: nb = 3'd4;
		endcase
	end

	fbfr_rdu u_rdu (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_go),
		.wr_addr (ADDR_W'(cmd.load_address)),
		.wr_data (cmd.load_byte),
		.req     (rd_req),
		.rsp     (rd_rsp)
	);

	// next step
	always_comb begin
		case (cw.jmp)
			J_NEXT:  pc_nxt = pc_q + 4'd1;
			J_START: pc_nxt = query_go ? pc_q + 4'd1 : pc_q;
			J_RD:    pc_nxt = rd_rsp.done ? pc_q + 4'd1 : pc_q;
			J_CHECK: pc_nxt = fail ? cw.target : pc_q + 4'd1;
			J_EMIT:  pc_nxt = out_free ? cw.target : pc_q;
			default: pc_nxt = cw.target;
		endcase
	end

	// datapath controls from the control word
	always_comb begin
		fail     = 1'b0;
		fail_st  = ST_BOUNDS;
		fail_val = '0;
		rd_req   = '0;
		case (cw.op)
			U_TBL: begin
				fail          = ({1'b0, tbl_q} + 13'd4) > vlen;
				rd_req.start  = !fail;
				rd_req.pos    = ADDR_W'(tbl_q);
				rd_req.nbytes = 3'd4;
			end
			U_VTCHK: begin
				if (vt_q[33]) begin
					fail    = 1'b1;
					fail_st = ST_NEGVT;
				end else begin
					fail = (vt_q + 34'd2) > 34'(vlen);
				end
				rd_req.start  = !fail;
				rd_req.pos    = ADDR_W'(vt_q[11:0]);
				rd_req.nbytes = 3'd2;
			end
			U_SLOT: begin
				fail     = slot_end > {2'b00, rd_rsp.word[15:0]};
				fail_st  = ST_ABSENT;
				fail_val = {1'b0, def_q};
			end
			U_SCHK: begin
				fail          = ({1'b0, sa_q} + 20'd2) > 20'(vlen);
				rd_req.start  = !fail;
				rd_req.pos    = ADDR_W'(sa_q);
				rd_req.nbytes = 3'd2;
			end
			U_FPOS: begin
				fail     = (rd_rsp.word[15:0] == 16'd0);
				fail_st  = ST_ABSENT;
				fail_val = {1'b0, def_q};
			end
			U_FCHK: begin
				fail          = ({1'b0, fpos_q} + 18'(nb)) > 18'(vlen);
				rd_req.start  = !fail;
				rd_req.pos    = ADDR_W'(fpos_q);
				rd_req.nbytes = nb;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_IDLE;
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_nxt;
			if (len_we) begin
				len_q <= len_wdata;
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_go) begin
			tbl_q <= cmd.table_position;
			fid_q <= cmd.field_index;
			acc_q <= cmd.access_type;
			def_q <= cmd.default_value;
		end
		if (cw.jmp == J_CHECK && fail) begin
			rval_q <= fail_val;
			rst_q  <= fail_st;
		end
		case (cw.op)
			U_VTCALC: vt_q <= {22'd0, tbl_q} - {{2{rd_rsp.word[31]}}, rd_rsp.word};
			U_SLOT:   sa_q <= {7'd0, vt_q[11:0]} + {1'b0, slot};
			U_FPOS:   fpos_q <= {5'd0, tbl_q} + {1'b0, rd_rsp.word[15:0]};
			U_FIN: begin
				rst_q <= ST_PRESENT;
				if (acc_q == AT_OFF) begin
					rval_q <= {16'd0, fpos_q} + {1'b0, rd_rsp.word};
				end else begin
					rval_q <= {1'b0, rd_rsp.word};
				end
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			res_q.value  <= rval_q;
			res_q.status <= rst_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: hw/rtl/fbfr_chk.sv
module fbfr_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_stall,
	input fbfr_pkg::cmd_t              cmd,
	input logic                        res_valid,
	input logic                        res_stall,
	input fbfr_pkg::res_t              res
);
	import fbfr_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result request dropped or changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd.kind == KIND_QUERY) |=> cmd_stall)
		else $error("query accepted without going busy");

	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd.kind == KIND_LOAD) |=> !cmd_stall)
		else $error("load request left the block busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_BOUNDS || res.status == ST_NEGVT)
		|-> (res.value == 33'd0))
		else $error("error result with non-zero value");

	a_absent_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_ABSENT) |-> !res.value[32])
		else $error("default result wider than 32 bits");

endmodule

bind flatbuffer_field_reader fbfr_chk u_fbfr_chk (.*);
